@@ rtl/vpfc_pkg.sv @@
// ----------------------------------------------------------------------------
// vpfc_pkg: shared types and constants
// Sequencer states, configuration register indexes and datapath widths for
// the velocity PI controller with feedforward.
// ----------------------------------------------------------------------------
package vpfc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEILING  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FLOOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FF_SCALE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_DEADBAND = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_DUTIES   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_FLAGS    = 3'd7;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_A_W = 41;
  localparam int unsigned MUL_B_W = 34;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  // Width of the low slice of the first operand; the high slice is the rest.
  localparam int unsigned MUL_SLICE_W = 21;

  // Duty accumulator with 9 fraction bits.
  localparam int unsigned ACC_W   = 60;
  localparam int unsigned INTEG_W = 40;
  localparam int unsigned EPS_Q24 = 17;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_FF,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_DT,
    ST_INTEG,
    ST_MUL_I2,
    ST_FINISH
  } seq_state_e;

endpackage

@@ rtl/vpfc_if.sv @@
// ----------------------------------------------------------------------------
// vpfc_if: word channels of the controller
// Input channel carries a step or clear request; output channel the duty.
// ----------------------------------------------------------------------------
interface vpfc_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] target_speed;
  logic signed [31:0] measured_speed;
  logic [23:0]        time_step;

  modport source (output valid, operation, target_speed, measured_speed, time_step,
                  input ready);
  modport sink (input valid, operation, target_speed, measured_speed, time_step,
                output ready);
endinterface

interface vpfc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] duty;
  logic               integrator_held;
  logic               updated;

  modport source (output valid, duty, integrator_held, updated, input ready);
  modport sink (input valid, duty, integrator_held, updated, output ready);
endinterface

@@ rtl/vpfc_mul.sv @@
// ----------------------------------------------------------------------------
// vpfc_mul: shared signed multiplier
// One signed product in two passes through a narrow multiplier: the low slice
// of the first operand, then the high slice accumulated on top of it.
// ----------------------------------------------------------------------------
module vpfc_mul (
  input  logic                                  clk_i,
  input  logic                                  hi_pass_i,
  input  logic signed [vpfc_pkg::MUL_A_W-1:0]   a_i,
  input  logic signed [vpfc_pkg::MUL_B_W-1:0]   b_i,
  output logic signed [vpfc_pkg::MUL_P_W-1:0]   prod_o
);
  import vpfc_pkg::*;

  logic signed [MUL_SLICE_W:0]         a_part;
  logic signed [MUL_SLICE_W+MUL_B_W:0] pp;
  logic signed [MUL_P_W-1:0]           part_q, prod_q;

  // The low slice is taken as unsigned and the high slice carries the sign.
  always_comb begin
    if (hi_pass_i) a_part = (MUL_SLICE_W + 1)'($signed(a_i[MUL_A_W-1:MUL_SLICE_W]));
    else           a_part = $signed({1'b0, a_i[MUL_SLICE_W-1:0]});
    pp = a_part * b_i;
  end

  // Operands stay put over both passes; the product holds until the next one.
  always_ff @(posedge clk_i) begin
    if (hi_pass_i) prod_q <= part_q + (MUL_P_W'(pp) <<< MUL_SLICE_W);
    else           part_q <= MUL_P_W'(pp);
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/velocity_pi_feedforward_controller.sv @@
// ----------------------------------------------------------------------------
// velocity_pi_feedforward_controller: velocity PI loop with feedforward
// Speed PI controller with target feedforward, direction bias, anti-windup,
// symmetric clamp and minimum duty.
// ----------------------------------------------------------------------------
// A control step returns its result word once a sequence is done: the
// feedforward, proportional, integral and integrator-increment products,
// and the integral product again after the update, all go one after the other
// through a single shared multiplier that forms each product from the low
// slice of the first operand, then the high slice accumulated; then the
// integrator is updated and the result is clamped and rounded, waiting while
// the output register is full. No new word is taken during a step. A clear
// word or a step with zero elapsed time answers in the cycle after acceptance.
// A new word is taken only while the sequencer is idle and the output
// register is free or being emptied in the same cycle. Configuration is
// written through a plain write port and must only change while the block is
// idle.
module velocity_pi_feedforward_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vpfc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [vpfc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  vpfc_in_if.sink                             item_i,
  vpfc_out_if.source                          result_o
);
  import vpfc_pkg::*;

  // Configuration registers.
  logic [23:0]        prop_gain_q, integ_gain_q;
  logic [14:0]        duty_ceiling_q, duty_floor_q;
  logic signed [31:0] ff_scale_q;
  logic [30:0]        bias_deadband_q;
  logic [31:0]        bias_duties_q;
  logic [1:0]         mode_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q     <= 24'd6554;
      integ_gain_q    <= 24'd327680;
      duty_ceiling_q  <= 15'd32767;
      duty_floor_q    <= 15'd0;
      ff_scale_q      <= '0;
      bias_deadband_q <= '0;
      bias_duties_q   <= '0;
      mode_flags_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PROP_GAIN:     prop_gain_q     <= cfg_wdata_i[23:0];
        CFG_INTEG_GAIN:    integ_gain_q    <= cfg_wdata_i[23:0];
        CFG_DUTY_CEILING:  duty_ceiling_q  <= cfg_wdata_i[14:0];
        CFG_DUTY_FLOOR:    duty_floor_q    <= cfg_wdata_i[14:0];
        CFG_FF_SCALE:      ff_scale_q      <= signed'(cfg_wdata_i);
        CFG_BIAS_DEADBAND: bias_deadband_q <= cfg_wdata_i[30:0];
        CFG_BIAS_DUTIES:   bias_duties_q   <= cfg_wdata_i;
        CFG_MODE_FLAGS:    mode_flags_q    <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  logic rev_allowed, up_positive;
  assign rev_allowed = mode_flags_q[0];
  assign up_positive = mode_flags_q[1];

  // Sequencer and datapath registers.
  seq_state_e state_q, state_d;
  logic       half_q, half_d;

  logic signed [32:0]        tgt_q, tgt_d;
  logic signed [32:0]        meas_q, meas_d;
  logic signed [33:0]        err_q, err_d;
  logic [23:0]               dt_q, dt_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic                      held_q, held_d;
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [15:0]        last_duty_q, last_duty_d;

  logic                      out_valid_q, out_valid_d;
  logic signed [15:0]        out_duty_q, out_duty_d;
  logic                      out_held_q, out_held_d;
  logic                      out_upd_q, out_upd_d;

  logic out_free, accept;
  assign out_free = !out_valid_q || result_o.ready;
  assign accept   = item_i.valid && item_i.ready;

  assign item_i.ready             = (state_q == ST_IDLE) && out_free;
  assign result_o.valid           = out_valid_q;
  assign result_o.duty            = out_duty_q;
  assign result_o.integrator_held = out_held_q;
  assign result_o.updated         = out_upd_q;

  // Shared multiplier; half_q selects the high pass of each product.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  vpfc_mul u_mul (
    .clk_i     (clk_i),
    .hi_pass_i (half_q),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .prod_o    (prod)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_FF: begin
        mul_a = MUL_A_W'(ff_scale_q);
        mul_b = MUL_B_W'(tgt_q);
      end
      ST_MUL_P: begin
        mul_a = $signed({17'd0, prop_gain_q});
        mul_b = err_q;
      end
      ST_MUL_I, ST_MUL_I2: begin
        mul_a = MUL_A_W'(integ_q);
        mul_b = $signed({10'd0, integ_gain_q});
      end
      ST_MUL_DT: begin
        mul_a = MUL_A_W'(err_q);
        mul_b = $signed({10'd0, dt_q});
      end
      default: ;
    endcase
  end

  // Input conditioning: absolute values when reverse is not allowed.
  logic signed [32:0] tgt_in, meas_in;
  always_comb begin
    tgt_in  = 33'(item_i.target_speed);
    meas_in = 33'(item_i.measured_speed);
    if (!rev_allowed) begin
      if (tgt_in < 0)  tgt_in  = -tgt_in;
      if (meas_in < 0) meas_in = -meas_in;
    end
  end

  // Direction bias chosen with the deadband; target first, then measurement.
  logic [32:0]             tgt_mag, meas_mag;
  logic                    dir_pos, dir_neg;
  logic signed [15:0]      bias_up, bias_down, bias_sel;
  logic signed [ACC_W-1:0] bias_term;
  always_comb begin
    tgt_mag   = tgt_q[32] ? 33'(-tgt_q) : 33'(tgt_q);
    meas_mag  = meas_q[32] ? 33'(-meas_q) : 33'(meas_q);
    dir_pos   = 1'b0;
    dir_neg   = 1'b0;
    if (tgt_mag > {2'b00, bias_deadband_q}) begin
      dir_pos = (tgt_q > 0);
      dir_neg = !(tgt_q > 0);
    end else if (meas_mag > {2'b00, bias_deadband_q}) begin
      dir_pos = (meas_q > 0);
      dir_neg = !(meas_q > 0);
    end
    bias_up   = signed'(bias_duties_q[15:0]);
    bias_down = signed'(bias_duties_q[31:16]);
    bias_sel  = '0;
    if (dir_pos)      bias_sel = up_positive ? bias_up : bias_down;
    else if (dir_neg) bias_sel = up_positive ? bias_down : bias_up;
    bias_term = ACC_W'(bias_sel) <<< 9;
  end

  // Product terms scaled to the accumulator's 9 fraction bits, floor rounding.
  logic signed [ACC_W-1:0] ff_term, pi_term, u_sum;
  logic signed [ACC_W-1:0] lim, flr, u_cl, u_mag;
  logic [14:0]             ceil_d, floor_d;
  logic signed [ACC_W-1:0] u_rnd;
  logic signed [33:0]      inc;
  logic signed [INTEG_W:0] integ_sum;
  logic signed [INTEG_W:0] integ_max, integ_min;

  always_comb begin
    ff_term = ACC_W'(prod >>> 16);
    pi_term = ACC_W'(prod >>> 8);
    u_sum   = acc_q + pi_term;

    ceil_d  = (duty_ceiling_q > duty_floor_q) ? duty_ceiling_q : duty_floor_q;
    floor_d = (duty_ceiling_q > duty_floor_q) ? duty_floor_q : duty_ceiling_q;
    lim     = $signed({(ACC_W - 24)'(0), ceil_d, 9'd0});
    flr     = $signed({(ACC_W - 24)'(0), floor_d, 9'd0});

    // Integrator increment rounded to nearest, ties up.
    inc       = 34'((prod + MUL_P_W'(64'sd1 <<< 23)) >>> 24);
    integ_sum = (INTEG_W + 1)'(integ_q) + (INTEG_W + 1)'(inc);
    integ_max = (INTEG_W + 1)'({1'b0, {(INTEG_W - 1){1'b1}}});
    integ_min = -integ_max - (INTEG_W + 1)'(1);

    // Clamp, minimum duty, reverse cut and final rounding.
    u_cl = u_sum;
    if (u_cl > lim)  u_cl = lim;
    if (u_cl < -lim) u_cl = -lim;
    u_mag = (u_cl < 0) ? -u_cl : u_cl;
    if ((floor_d != '0) && (u_cl != '0) && (u_mag < flr)) begin
      if (tgt_q != '0) u_cl = (u_cl >= 0) ? flr : -flr;
      else             u_cl = '0;
    end
    if (!rev_allowed && (u_cl < 0)) u_cl = '0;
    u_rnd = (u_cl + ACC_W'(256)) >>> 9;
  end

  // Next state. Each multiply state holds through both passes, low then high.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_MUL_FF, ST_MUL_P, ST_MUL_I, ST_MUL_DT, ST_MUL_I2: half_d = !half_q;
      default: half_d = 1'b0;
    endcase
    case (state_q)
      ST_IDLE: begin
        if (accept && (item_i.operation == OP_STEP) && (item_i.time_step != '0)) begin
          state_d = ST_MUL_FF;
        end
      end
      ST_MUL_FF: if (half_q) state_d = ST_MUL_P;
      ST_MUL_P:  if (half_q) state_d = ST_MUL_I;
      ST_MUL_I:  if (half_q) state_d = ST_MUL_DT;
      ST_MUL_DT: if (half_q) state_d = ST_INTEG;
      ST_INTEG:  state_d = ST_MUL_I2;
      ST_MUL_I2: if (half_q) state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output updates.
  always_comb begin
    tgt_d       = tgt_q;
    meas_d      = meas_q;
    err_d       = err_q;
    dt_d        = dt_q;
    acc_d       = acc_q;
    held_d      = held_q;
    integ_d     = integ_q;
    last_duty_d = last_duty_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_duty_d  = out_duty_q;
    out_held_d  = out_held_q;
    out_upd_d   = out_upd_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (item_i.operation == OP_CLEAR) begin
            integ_d     = '0;
            last_duty_d = '0;
            out_valid_d = 1'b1;
            out_duty_d  = '0;
            out_held_d  = 1'b0;
            out_upd_d   = 1'b0;
          end else if (item_i.time_step == '0) begin
            out_valid_d = 1'b1;
            out_duty_d  = last_duty_q;
            out_held_d  = 1'b0;
            out_upd_d   = 1'b0;
          end else begin
            tgt_d  = tgt_in;
            meas_d = meas_in;
            err_d  = 34'(tgt_in) - 34'(meas_in);
            dt_d   = item_i.time_step;
          end
        end
      end
      ST_MUL_P: acc_d = ff_term + bias_term;
      ST_MUL_I: begin
        // The proportional product is added once, on the high pass.
        if (half_q) acc_d = u_sum;
      end
      ST_MUL_DT: begin
        // Anti-windup: freeze when already at a limit and pushing further.
        held_d = ((u_sum >= lim - $signed(ACC_W'(EPS_Q24))) && (err_q > 0)) ||
                 ((u_sum <= -lim + $signed(ACC_W'(EPS_Q24))) && (err_q < 0));
        acc_d  = acc_q;
      end
      ST_INTEG: begin
        if (!held_q) begin
          if (integ_sum > integ_max)      integ_d = INTEG_W'(integ_max);
          else if (integ_sum < integ_min) integ_d = INTEG_W'(integ_min);
          else                            integ_d = INTEG_W'(integ_sum);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          last_duty_d = 16'(u_rnd);
          out_valid_d = 1'b1;
          out_duty_d  = 16'(u_rnd);
          out_held_d  = held_q;
          out_upd_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      last_duty_q <= '0;
    end else begin
      state_q     <= state_d;
      half_q      <= half_d;
      out_valid_q <= out_valid_d;
      integ_q     <= integ_d;
      last_duty_q <= last_duty_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    tgt_q      <= tgt_d;
    meas_q     <= meas_d;
    err_q      <= err_d;
    dt_q       <= dt_d;
    acc_q      <= acc_d;
    held_q     <= held_d;
    out_duty_q <= out_duty_d;
    out_held_q <= out_held_d;
    out_upd_q  <= out_upd_d;
  end

endmodule

@@ dv/velocity_pi_feedforward_controller_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// velocity_pi_feedforward_controller_checker: duty predictor and comparator
// Watches the request and duty channels and the configuration port, computes
// the expected duty word for every accepted request and compares it with
// each accepted duty word in order.
// ----------------------------------------------------------------------------
module velocity_pi_feedforward_controller_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vpfc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [vpfc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  vpfc_in_if.sink                           req_mon,
  vpfc_out_if.sink                          duty_mon,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                duty_seen_o
);
  import vpfc_pkg::*;

  typedef struct packed {
    logic signed [15:0] duty;
    logic               held;
    logic               updated;
  } duty_word_t;

  logic [23:0]        kp, ki;
  logic [14:0]        ceil_r, floor_r;
  logic signed [31:0] ff_k;
  logic [30:0]        deadband;
  logic [31:0]        bias_pair;
  logic [1:0]         mode;
  logic signed [39:0] integ;
  logic signed [15:0] prev_duty;
  duty_word_t         duty_q[$];

  assign pending_o = duty_q.size();

  // Arithmetic shift right rounding toward minus infinity.
  function automatic logic signed [127:0] sra(logic signed [127:0] v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [127:0] mag(logic signed [127:0] v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic compute_duty(input logic op, input logic signed [31:0] ts,
                              input logic signed [31:0] ms, input logic [23:0] dt);
    logic signed [127:0] tgt, meas, err, ff, p, bias, ival, u, lim, flr, inc, ni;
    logic signed [127:0] cmax, cmin, db, eps;
    logic signed [15:0]  up_b, dn_b;
    int                  dir;
    logic                held;
    duty_word_t          w;
    if (op == OP_CLEAR) begin
      integ = '0;
      prev_duty = '0;
      w = '{16'sd0, 1'b0, 1'b0};
    end else if (dt == 0) begin
      w = '{prev_duty, 1'b0, 1'b0};
    end else begin
      eps = $signed(128'(EPS_Q24));
      cmax = (ceil_r > floor_r) ? ceil_r : floor_r;
      cmin = (ceil_r > floor_r) ? floor_r : ceil_r;
      tgt = ts;
      meas = ms;
      if (!mode[0]) begin
        tgt = mag(tgt);
        meas = mag(meas);
      end
      err = tgt - meas;
      ff = sra(128'(ff_k) * tgt, 16);
      db = deadband;
      up_b = bias_pair[15:0];
      dn_b = bias_pair[31:16];
      dir = 0;
      if (mag(tgt) > db) dir = (tgt > 0) ? 1 : -1;
      else if (mag(meas) > db) dir = (meas > 0) ? 1 : -1;
      bias = 0;
      if (dir != 0) begin
        if (mode[1]) bias = (dir > 0) ? up_b : dn_b;
        else bias = (dir > 0) ? dn_b : up_b;
      end
      bias = bias * 512;
      p = sra(128'(kp) * err, 8);
      lim = cmax * 512;
      ival = sra(128'(ki) * 128'(integ), 8);
      u = ff + bias + p + ival;
      held = (u >= lim - eps && err > 0) || (u <= -lim + eps && err < 0);
      if (!held) begin
        inc = sra(err * 128'(dt) + (128'sd1 <<< 23), 24);
        ni = 128'(integ) + inc;
        if (ni > (128'sd1 <<< 39) - 1) ni = (128'sd1 <<< 39) - 1;
        if (ni < -(128'sd1 <<< 39)) ni = -(128'sd1 <<< 39);
        integ = ni[39:0];
      end
      ival = sra(128'(ki) * 128'(integ), 8);
      u = ff + bias + p + ival;
      if (u > lim) u = lim;
      if (u < -lim) u = -lim;
      flr = cmin * 512;
      if (cmin > 0 && u != 0 && mag(u) < flr) u = (tgt != 0) ? ((u >= 0) ? flr : -flr) : 0;
      if (!mode[0] && u < 0) u = 0;
      u = sra(u + 256, 9);
      prev_duty = u[15:0];
      w = '{u[15:0], held, 1'b1};
    end
    duty_q.push_back(w);
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    duty_word_t exp_w;
    if (!rst_ni) begin
      kp <= 24'd6554; ki <= 24'd327680; ceil_r <= 15'd32767; floor_r <= '0;
      ff_k <= '0; deadband <= '0; bias_pair <= '0; mode <= '0;
      integ = '0; prev_duty = '0;
      fail_count_o <= 0; duty_seen_o <= 0;
      duty_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PROP_GAIN:     kp <= cfg_wdata_i[23:0];
          CFG_INTEG_GAIN:    ki <= cfg_wdata_i[23:0];
          CFG_DUTY_CEILING:  ceil_r <= cfg_wdata_i[14:0];
          CFG_DUTY_FLOOR:    floor_r <= cfg_wdata_i[14:0];
          CFG_FF_SCALE:      ff_k <= cfg_wdata_i;
          CFG_BIAS_DEADBAND: deadband <= cfg_wdata_i[30:0];
          CFG_BIAS_DUTIES:   bias_pair <= cfg_wdata_i;
          CFG_MODE_FLAGS:    mode <= cfg_wdata_i[1:0];
          default: ;
        endcase
      end
      // Duty word first, so a same-edge request cannot be matched against it.
      if (duty_mon.valid && duty_mon.ready) begin
        duty_seen_o <= duty_seen_o + 1;
        if (duty_q.size() == 0) begin
          $display("%0t: unexpected duty word %0d", $time, duty_mon.duty);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_w = duty_q.pop_front();
          if (exp_w.duty !== duty_mon.duty || exp_w.held !== duty_mon.integrator_held ||
              exp_w.updated !== duty_mon.updated) begin
            $display("%0t: mismatch expected duty %0d held %0b updated %0b, got %0d %0b %0b",
                     $time, exp_w.duty, exp_w.held, exp_w.updated, duty_mon.duty,
                     duty_mon.integrator_held, duty_mon.updated);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // State is kept in variables updated in the task; blocking use is intended.
      if (req_mon.valid && req_mon.ready)
        compute_duty(req_mon.operation, req_mon.target_speed, req_mon.measured_speed,
                     req_mon.time_step);
    end
  end
endmodule

@@ dv/velocity_pi_feedforward_controller_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// velocity_pi_feedforward_controller_test: top of the controller testbench
// Writes several configuration sets, sends directed and random step and clear
// words with random gaps and output stalls, and reports the verdict from the
// checker's failure and pending counts.
// ----------------------------------------------------------------------------
module velocity_pi_feedforward_controller_test;
  import vpfc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  int fail_count, pending, duty_seen, cycle_count, sent;
  logic long_stall = 1'b0;

  vpfc_in_if  req_ch();
  vpfc_out_if duty_ch();

  velocity_pi_feedforward_controller dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .item_i(req_ch.sink), .result_o(duty_ch.source)
  );

  velocity_pi_feedforward_controller_checker checker_u (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .req_mon(req_ch.sink), .duty_mon(duty_ch.sink),
    .fail_count_o(fail_count), .pending_o(pending), .duty_seen_o(duty_seen)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.operation = OP_STEP;
    req_ch.target_speed = '0;
    req_ch.measured_speed = '0;
    req_ch.time_step = '0;
    duty_ch.ready = 1'b0;
  end

  // Generous timeout: the run is declared failed if it does not finish in time.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The receiving side stalls a random number of cycles before each word,
  // and once holds off for a long stretch after a long stall is requested.
  initial begin
    int gap;
    bit stall_taken;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      repeat (gap) @(posedge clk_i);
      if (long_stall && !stall_taken) begin
        stall_taken = 1'b1;
        repeat (300) @(posedge clk_i);
      end
      duty_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!duty_ch.valid) @(posedge clk_i);
      duty_ch.ready <= 1'b0;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every expected duty word has come, then lets the sequencer settle.
  task automatic drain;
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // The request stays valid after acceptance until the next gap or drain.
  task automatic send_word(input logic op, input logic [31:0] t, input logic [31:0] m,
                           input logic [23:0] dt, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.operation <= op;
    req_ch.target_speed <= t;
    req_ch.measured_speed <= m;
    req_ch.time_step <= dt;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  // Speeds mostly near zero so the loop leaves saturation, sometimes anywhere.
  function automatic logic [31:0] pick_speed();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
      2: return 32'(signed'($urandom_range(0, 2000)) - 1000);
      default: return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  task automatic random_config(input int mode);
    write_reg(CFG_PROP_GAIN, (mode == 0) ? 32'hFFFFFF : $urandom_range(0, 20000));
    write_reg(CFG_INTEG_GAIN, (mode == 0) ? 32'hFFFFFF : $urandom_range(0, 400000));
    write_reg(CFG_DUTY_CEILING, (mode == 1) ? 0 : $urandom_range(0, 32767));
    write_reg(CFG_DUTY_FLOOR, (mode == 2) ? 32767 : $urandom_range(0, 8000));
    write_reg(CFG_FF_SCALE, (mode == 0) ? 32'h8000_0000 : $urandom);
    write_reg(CFG_BIAS_DEADBAND, (mode == 2) ? 32'h7FFF_FFFF : $urandom_range(0, 300000));
    write_reg(CFG_BIAS_DUTIES, $urandom);
    write_reg(CFG_MODE_FLAGS, $urandom_range(0, 3));
  endtask

  initial begin
    int n;
    logic [23:0] dt;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: at reset configuration a clear, zero time step, extremes of
    // speed and the most negative speed with reverse off; then, with reverse on and
    // floor above ceiling, a run of full-scale error that holds the duty at its limit.
    send_word(OP_CLEAR, 0, 0, 0, 0);
    send_word(OP_STEP, 32'h0001_0000, 0, 24'h010000, 0);
    send_word(OP_STEP, 32'h0001_0000, 0, 24'h000000, 0);
    send_word(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFFFFFF, 0);
    send_word(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF, 0);
    send_word(OP_STEP, 0, 32'h0000_8000, 24'h000001, 0);
    drain();
    write_reg(CFG_MODE_FLAGS, 2'b01);
    write_reg(CFG_DUTY_FLOOR, 32'd4000);
    write_reg(CFG_DUTY_CEILING, 32'd1000);
    for (int i = 0; i < 8; i++)
      send_word(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF, 1);
    send_word(OP_STEP, 0, 32'h0000_0100, 24'h000100, 0);
    send_word(OP_STEP, 32'h8000_0000, 0, 24'hFFFFFF, 0);
    send_word(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF, 0);
    drain();

    // Random phases, each under a fresh configuration; phase zero uses the
    // largest gains and the most negative feedforward.
    for (int ph = 0; ph < 11; ph++) begin
      random_config(ph);
      n = 0;
      while (n < 50) begin
        dt = ($urandom_range(0, 9) == 0) ? 24'd0 :
             ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'($urandom_range(1, 20000));
        if (ph == 5 && n == 10) long_stall <= 1'b1;
        send_word(($urandom_range(0, 24) == 0) ? OP_CLEAR : OP_STEP,
                  pick_speed(), pick_speed(), dt, ph == 5 && n < 20);
        n++;
      end
      // Sender waits for every expected word before the next configuration.
      drain();
    end
    // Final configuration with extreme values in several registers.
    write_reg(CFG_PROP_GAIN, 0);
    write_reg(CFG_INTEG_GAIN, 0);
    write_reg(CFG_DUTY_CEILING, 32767);
    write_reg(CFG_DUTY_FLOOR, 0);
    write_reg(CFG_FF_SCALE, 32'h7FFF_FFFF);
    write_reg(CFG_BIAS_DEADBAND, 0);
    write_reg(CFG_BIAS_DUTIES, 32'hFFFF_FFFF);
    write_reg(CFG_MODE_FLAGS, 2'b11);
    for (int i = 0; i < 10; i++)
      send_word(OP_STEP, pick_speed(), pick_speed(), 24'($urandom_range(1, 24'hFFFFFF)), 0);
    drain();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d request words and checked %0d duty words over %0d configurations.",
             sent, duty_seen, 14);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
